FILE: src/gif_lzw_decoder_unit_defines.svh
// assertion macros for the gif lzw decoder unit
// no dependencies; included by the top level only
`ifndef GIF_LZW_DECODER_UNIT_DEFINES_SVH
`define GIF_LZW_DECODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check on every clock edge out of reset
`define GLD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on every clock edge, reset included
`define GLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLD_ASSERT(lbl, clk, rstn, prop, msg)
`define GLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/gld_pkg.sv
// types and codes shared by the gif lzw decoder unit
// no dependencies
`timescale 1ns / 1ps
package gld_pkg;

  typedef enum logic [2:0] {
    ST_INDEX     = 3'd0,
    ST_TAKEN     = 3'd1,
    ST_REFUSED   = 3'd2,
    ST_NEED_MORE = 3'd3,
    ST_END       = 3'd4,
    ST_DAMAGED   = 3'd5,
    ST_TOO_LARGE = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FIN_RUN     = 2'd0,
    FIN_END     = 2'd1,
    FIN_DAMAGED = 2'd2,
    FIN_LARGE   = 2'd3
  } fin_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_FINISH,
    S_POP
  } state_e;

  localparam logic CFG_MIN_CODE_SIZE = 1'b0;
  localparam logic CFG_OUTPUT_LIMIT  = 1'b1;
  localparam logic ACT_OFFER         = 1'b0;
  localparam logic ACT_REQUEST       = 1'b1;

  localparam logic [3:0]  MCS_MIN   = 4'd2;
  localparam logic [3:0]  MCS_MAX   = 4'd8;
  localparam logic [5:0]  BUF_ROOM  = 6'd24;
  localparam logic [5:0]  BYTE_BITS = 6'd8;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] index;
    logic       string_last;
  } out_item_t;

endpackage

FILE: src/gld_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/gif_lzw_decoder_unit.sv
// gif lzw decoder: byte offers are answered from idle; a pop from a held string goes
// through the stack ram. a request that decodes a code goes through decode, the chain
// walk over the prefix/suffix rams, one entry a cycle, then finish and pop; a clear
// code met in decode is taken there before the next code is read.
// afterwards each index of that string is handed out through the stack ram.
// reset (async, active low) restores min code size 8, limit all ones, empty decoder.
`timescale 1ns / 1ps
`include "gif_lzw_decoder_unit_defines.svh"
module gif_lzw_decoder_unit #(
  parameter int TABLE_ENTRIES  = 4096,
  parameter int MAX_CODE_WIDTH = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gld_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gld_pkg::out_item_t out_item_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = MAX_CODE_WIDTH;
  localparam int NW = ((CW > AW) ? CW : AW) + 1;
  localparam logic [NW-1:0] TAB_SIZE = NW'(TABLE_ENTRIES);
  localparam logic [AW:0]   SPAN_MAX = (AW+1)'(TABLE_ENTRIES);
  localparam logic [3:0]    CW_MAX   = 4'(MAX_CODE_WIDTH);

  gld_pkg::state_e  state_q, state_d;
  gld_pkg::fin_e    fin_q, fin_d;
  logic [3:0]       mcs_q, mcs_d;
  logic [31:0]      limit_q, limit_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic [31:0]      buf_q, buf_d;
  logic [5:0]       bits_q, bits_d;
  logic [7:0]       sub_q, sub_d;
  logic             closed_q, closed_d;
  logic [NW-1:0]    nfc_q, nfc_d;
  logic [3:0]       cw_q, cw_d;
  logic [NW-1:0]    prev_q, prev_d;
  logic             pv_q, pv_d;
  logic [7:0]       first_q, first_d;
  logic [31:0]      idx_q, idx_d;
  logic [NW-1:0]    step_q, step_d;
  logic [NW-1:0]    code_q, code_d;
  logic [AW:0]      span_q, span_d;
  logic [7:0]       root_q, root_d;
  logic             out_valid_q, out_valid_d;
  gld_pkg::out_item_t out_item_q, out_item_d;

  // table and stack ram ports
  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [AW-1:0] pre_wdata, pre_rdata;
  logic [7:0]    suf_wdata, suf_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata, stk_rdata;

  gld_ram #(.WIDTH(AW), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(pre_wdata),
    .raddr_i(tab_raddr), .rdata_o(pre_rdata)
  );
  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(suf_wdata),
    .raddr_i(tab_raddr), .rdata_o(suf_rdata)
  );
  gld_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // derived codes and the next code from the bit buffer
  logic [NW-1:0] clear_c, endc_c;
  logic [CW:0]   one_sh;
  logic [CW-1:0] code_mask;
  logic [NW-1:0] code_c;
  logic          accept;
  logic [3:0]    mcs_cfg;
  logic [NW-1:0] nfc_inc;
  logic [NW-1:0] cw_pow;

  assign clear_c   = NW'(1) << mcs_q;
  assign endc_c    = clear_c + NW'(1);
  assign one_sh    = (CW+1)'(1) << cw_q;
  assign code_mask = CW'(one_sh - (CW+1)'(1));
  assign code_c    = NW'(buf_q[CW-1:0] & code_mask);
  assign accept    = in_valid_i && !in_stall_o;
  assign nfc_inc   = nfc_q + NW'(1);
  assign cw_pow    = NW'(1) << cw_q;
  assign mcs_cfg   = (cfg_data_i[3:0] < gld_pkg::MCS_MIN) ? gld_pkg::MCS_MIN :
                     (cfg_data_i[3:0] > gld_pkg::MCS_MAX) ? gld_pkg::MCS_MAX :
                     cfg_data_i[3:0];

  assign in_stall_o  = !(state_q == gld_pkg::S_IDLE && (!out_valid_q || !out_stall_i));
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign stk_raddr   = AW'(cnt_q - (AW+1)'(1));

  // next state, datapath and ram control
  always_comb begin
    state_d = state_q;  fin_d = fin_q;     mcs_d = mcs_q;     limit_d = limit_q;
    cnt_d = cnt_q;      buf_d = buf_q;     bits_d = bits_q;   sub_d = sub_q;
    closed_d = closed_q; nfc_d = nfc_q;    cw_d = cw_q;       prev_d = prev_q;
    pv_d = pv_q;        first_d = first_q; idx_d = idx_q;     step_d = step_q;
    code_d = code_q;    span_d = span_q;   root_d = root_q;
    out_item_d = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    tab_we = 1'b0;  tab_waddr = nfc_q[AW-1:0];
    pre_wdata = prev_q[AW-1:0];  suf_wdata = first_q;
    tab_raddr = step_q[AW-1:0];
    stk_we = 1'b0;  stk_waddr = cnt_q[AW-1:0];  stk_wdata = first_q;

    case (state_q)
      gld_pkg::S_IDLE: begin
        if (accept) begin
          out_item_d = '0;
          if (in_item_i.action == gld_pkg::ACT_OFFER) begin
            out_valid_d = 1'b1;
            if (fin_q == gld_pkg::FIN_DAMAGED) begin
              out_item_d.status = gld_pkg::ST_DAMAGED;
            end else if (fin_q == gld_pkg::FIN_LARGE) begin
              out_item_d.status = gld_pkg::ST_TOO_LARGE;
            end else if (fin_q == gld_pkg::FIN_END || closed_q) begin
              out_item_d.status = gld_pkg::ST_END;
            end else if (sub_q == 8'd0) begin
              // sub-block length byte
              if (in_item_i.data_byte == 8'd0) closed_d = 1'b1;
              else sub_d = in_item_i.data_byte;
              out_item_d.status = gld_pkg::ST_TAKEN;
            end else if (bits_q > gld_pkg::BUF_ROOM) begin
              out_item_d.status = gld_pkg::ST_REFUSED;
            end else begin
              buf_d  = buf_q | (32'(in_item_i.data_byte) << bits_q);
              bits_d = bits_q + gld_pkg::BYTE_BITS;
              sub_d  = sub_q - 8'd1;
              out_item_d.status = gld_pkg::ST_TAKEN;
            end
          end else if (fin_q == gld_pkg::FIN_DAMAGED) begin
            out_valid_d = 1'b1;
            out_item_d.status = gld_pkg::ST_DAMAGED;
          end else if (fin_q == gld_pkg::FIN_LARGE) begin
            out_valid_d = 1'b1;
            out_item_d.status = gld_pkg::ST_TOO_LARGE;
          end else if (cnt_q != '0) begin
            cnt_d   = cnt_q - (AW+1)'(1);
            state_d = gld_pkg::S_POP;
          end else begin
            state_d = gld_pkg::S_DECODE;
          end
        end
      end

      gld_pkg::S_DECODE: begin
        out_item_d = '0;
        if (fin_q == gld_pkg::FIN_END) begin
          out_valid_d = 1'b1;
          out_item_d.status = gld_pkg::ST_END;
          state_d = gld_pkg::S_IDLE;
        end else if (bits_q < 6'(cw_q)) begin
          out_valid_d = 1'b1;
          if (closed_q) begin
            fin_d = gld_pkg::FIN_END;
            out_item_d.status = gld_pkg::ST_END;
          end else begin
            out_item_d.status = gld_pkg::ST_NEED_MORE;
          end
          state_d = gld_pkg::S_IDLE;
        end else begin
          buf_d  = buf_q >> cw_q;
          bits_d = bits_q - 6'(cw_q);
          if (code_c == endc_c) begin
            fin_d = gld_pkg::FIN_END;
            out_valid_d = 1'b1;
            out_item_d.status = gld_pkg::ST_END;
            state_d = gld_pkg::S_IDLE;
          end else if (code_c == clear_c) begin
            nfc_d = endc_c + NW'(1);
            cw_d  = mcs_q + 4'd1;
            pv_d  = 1'b0;
          end else if (code_c < nfc_q) begin
            step_d = code_c;  tab_raddr = code_c[AW-1:0];
            code_d = code_c;  span_d = '0;
            state_d = gld_pkg::S_WALK;
          end else if (code_c == nfc_q && pv_q && nfc_q < TAB_SIZE) begin
            // code names the entry being built: string of previous plus its first
            stk_we = 1'b1;  stk_wdata = first_q;
            cnt_d  = cnt_q + (AW+1)'(1);
            step_d = prev_q;  tab_raddr = prev_q[AW-1:0];
            code_d = code_c;  span_d = (AW+1)'(1);
            state_d = gld_pkg::S_WALK;
          end else begin
            fin_d = gld_pkg::FIN_DAMAGED;
            out_valid_d = 1'b1;
            out_item_d.status = gld_pkg::ST_DAMAGED;
            state_d = gld_pkg::S_IDLE;
          end
        end
      end

      gld_pkg::S_WALK: begin
        // one chain entry a cycle, ram data belongs to step_q
        if (step_q >= clear_c) begin
          if (span_q >= SPAN_MAX) begin
            fin_d = gld_pkg::FIN_DAMAGED;
            cnt_d = '0;
            out_valid_d = 1'b1;
            out_item_d = '0;
            out_item_d.status = gld_pkg::ST_DAMAGED;
            state_d = gld_pkg::S_IDLE;
          end else begin
            stk_we = 1'b1;  stk_wdata = suf_rdata;
            cnt_d  = cnt_q + (AW+1)'(1);
            span_d = span_q + (AW+1)'(1);
            step_d = NW'(pre_rdata);  tab_raddr = pre_rdata;
          end
        end else begin
          stk_we = 1'b1;  stk_wdata = step_q[7:0];
          cnt_d  = cnt_q + (AW+1)'(1);
          span_d = span_q + (AW+1)'(1);
          root_d = step_q[7:0];
          state_d = gld_pkg::S_FINISH;
        end
      end

      gld_pkg::S_FINISH: begin
        out_item_d = '0;
        if (span_q > SPAN_MAX) begin
          fin_d = gld_pkg::FIN_DAMAGED;  cnt_d = '0;
          out_valid_d = 1'b1;  out_item_d.status = gld_pkg::ST_DAMAGED;
          state_d = gld_pkg::S_IDLE;
        end else if ({1'b0, idx_q} + 33'(span_q) > {1'b0, limit_q}) begin
          fin_d = gld_pkg::FIN_LARGE;  cnt_d = '0;
          out_valid_d = 1'b1;  out_item_d.status = gld_pkg::ST_TOO_LARGE;
          state_d = gld_pkg::S_IDLE;
        end else begin
          // add the new table entry when there is a previous code and room, and start handing out the string
          if (pv_q && nfc_q < TAB_SIZE) begin
            tab_we = 1'b1;  suf_wdata = root_q;
            nfc_d = nfc_inc;
            if (nfc_inc == cw_pow && cw_q < CW_MAX) cw_d = cw_q + 4'd1;
          end
          prev_d  = code_q;  pv_d = 1'b1;  first_d = root_q;
          idx_d   = idx_q + 32'(span_q);
          cnt_d   = cnt_q - (AW+1)'(1);
          state_d = gld_pkg::S_POP;
        end
      end

      gld_pkg::S_POP: begin
        out_valid_d = 1'b1;
        out_item_d.status = gld_pkg::ST_INDEX;
        out_item_d.index = stk_rdata;
        out_item_d.string_last = (cnt_q == '0);
        state_d = gld_pkg::S_IDLE;
      end

      default: state_d = gld_pkg::S_IDLE;
    endcase

    // configuration writes; a new code size restarts the frame
    if (cfg_we_i) begin
      if (cfg_index_i == gld_pkg::CFG_MIN_CODE_SIZE) begin
        mcs_d = mcs_cfg;  cnt_d = '0;  buf_d = '0;  bits_d = '0;  sub_d = '0;
        closed_d = 1'b0;  nfc_d = (NW'(1) << mcs_cfg) + NW'(2);
        cw_d = mcs_cfg + 4'd1;  prev_d = '0;  pv_d = 1'b0;  first_d = '0;
        idx_d = '0;  fin_d = gld_pkg::FIN_RUN;
      end else begin
        limit_d = cfg_data_i;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gld_pkg::S_IDLE;  fin_q <= gld_pkg::FIN_RUN;
      mcs_q <= gld_pkg::MCS_MAX;   limit_q <= '1;
      cnt_q <= '0;  buf_q <= '0;  bits_q <= '0;  sub_q <= '0;  closed_q <= 1'b0;
      nfc_q <= (NW'(1) << gld_pkg::MCS_MAX) + NW'(2);
      cw_q <= gld_pkg::MCS_MAX + 4'd1;
      prev_q <= '0;  pv_q <= 1'b0;  first_q <= '0;  idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;  fin_q <= fin_d;  mcs_q <= mcs_d;  limit_q <= limit_d;
      cnt_q <= cnt_d;  buf_q <= buf_d;  bits_q <= bits_d;  sub_q <= sub_d;
      closed_q <= closed_d;  nfc_q <= nfc_d;  cw_q <= cw_d;  prev_q <= prev_d;
      pv_q <= pv_d;  first_q <= first_d;  idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    step_q <= step_d;  code_q <= code_d;  span_q <= span_d;  root_q <= root_d;
    out_item_q <= out_item_d;
  end

  // checks
  `GLD_ASSERT(a_pop_slot_free, clk_i, rst_ni,
    (state_q == gld_pkg::S_POP) |-> !(out_valid_q && out_stall_i),
    "pop with output slot busy")
  `GLD_ASSERT(a_decode_empty, clk_i, rst_ni,
    (state_q == gld_pkg::S_DECODE) |-> (cnt_q == '0),
    "decode with stack not empty")
  `GLD_ASSERT_ALWAYS(a_stack_bound, clk_i,
    (cnt_q <= SPAN_MAX) || !rst_ni,
    "stack count overflow")

endmodule
